FILE: hw/rtl/calendar_time_to_unix_ns_unit_macros.svh
// ----------------------------------------------------------------------------
// calendar_time_to_unix_ns_unit_macros.svh
// Assertion macros shared by the calendar-to-epoch checker.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TIME_TO_UNIX_NS_UNIT_MACROS_SVH
`define CALENDAR_TIME_TO_UNIX_NS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CT2U_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ct2u assertion failed");

// Invariant that holds on every cycle out of reset.
`define CT2U_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ct2u invariant failed");

`endif

FILE: hw/rtl/ct2u_pkg.sv
// ----------------------------------------------------------------------------
// ct2u_pkg
// Types, constants and the month table for the calendar-to-epoch converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ct2u_pkg;

    localparam logic [11:0] YEAR_FIRST    = 12'd1970;
    localparam logic [11:0] YEAR_LAST     = 12'd2099;
    localparam logic [3:0]  MONTHS_MAX    = 4'd12;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;

    // One transaction in.
    typedef struct packed {
        logic [11:0] year_full;
        logic [3:0]  month_num;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_val;
        logic [5:0]  second_val;
    } t_cal_in;

    // One result out.
    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [61:0] epoch_nanoseconds;
    } t_epoch_out;

    // Day count and time of day handed from the day-count stages.
    typedef struct packed {
        logic [15:0] days;
        logic [16:0] tod_secs;
    } t_day_sum;

    // Days before the first of a month in a common year; twelve means a full year.
    function automatic logic [8:0] days_before_month(input logic [3:0] full_months);
        logic [8:0] d;
        begin
            case (full_months)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                4'd11:   d = 9'd334;
                default: d = 9'd365;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ct2u_day_count.sv
// ----------------------------------------------------------------------------
// ct2u_day_count
// Two pipeline stages: decode the calendar fields, then sum days since 1970.
// ----------------------------------------------------------------------------
`default_nettype none

module ct2u_day_count (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire ct2u_pkg::t_cal_in  i_cal,
    output logic                    o_valid,
    output ct2u_pkg::t_day_sum      o_sum
);
    import ct2u_pkg::*;

    // Stage A
    logic        r_a_valid, n_a_valid;
    logic [7:0]  r_a_yoff,  n_a_yoff;
    logic [8:0]  r_a_mdays, n_a_mdays;
    logic [4:0]  r_a_dm1,   n_a_dm1;
    logic [16:0] r_a_tod,   n_a_tod;
    // Stage B
    logic        r_b_valid, n_b_valid;
    t_day_sum    r_b_sum,   n_b_sum;

    logic [11:0] year_c;
    logic [3:0]  full_months;
    logic        leap;
    logic [8:0]  leaps_since;

    always_comb begin
        if (i_cal.year_full < YEAR_FIRST) begin
            year_c = YEAR_FIRST;
        end else if (i_cal.year_full > YEAR_LAST) begin
            year_c = YEAR_LAST;
        end else begin
            year_c = i_cal.year_full;
        end
        n_a_yoff = 8'(year_c - YEAR_FIRST);

        if (i_cal.month_num == 4'd0) begin
            full_months = 4'd0;
        end else if (i_cal.month_num - 4'd1 > MONTHS_MAX) begin
            full_months = MONTHS_MAX;
        end else begin
            full_months = i_cal.month_num - 4'd1;
        end

        // In 1970..2099 a year is leap exactly when divisible by four; 1970 is two past one.
        leap      = (n_a_yoff[1:0] == 2'd2);
        n_a_mdays = days_before_month(full_months)
                  + {8'd0, (full_months >= 4'd2) && leap};

        n_a_dm1 = (i_cal.day_of_month == 5'd0) ? 5'd0 : i_cal.day_of_month - 5'd1;

        n_a_tod = 17'(i_cal.hour_of_day * 17'(SECS_PER_HOUR))
                + 17'(i_cal.minute_val * 17'(SECS_PER_MIN))
                + 17'(i_cal.second_val);
        n_a_valid = i_valid;

        // Leap days in 1970..year-1.
        leaps_since    = 9'(r_a_yoff) + 9'd1;
        n_b_sum.days   = 16'(16'(r_a_yoff) * DAYS_PER_YEAR)
                       + 16'(leaps_since[8:2])
                       + 16'(r_a_mdays)
                       + 16'(r_a_dm1);
        n_b_sum.tod_secs = r_a_tod;
        n_b_valid        = r_a_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
        r_a_yoff  <= n_a_yoff;
        r_a_mdays <= n_a_mdays;
        r_a_dm1   <= n_a_dm1;
        r_a_tod   <= n_a_tod;
        r_b_sum   <= n_b_sum;
    end

    assign o_valid = r_b_valid;
    assign o_sum   = r_b_sum;

endmodule

`default_nettype wire

FILE: hw/rtl/calendar_time_to_unix_ns_unit.sv
// A started transaction reaches the o_valid strobe through the stage A, B, C and D registers.
// Throughput: one transaction per cycle; o_busy stays low, the receiver cannot stall.
// Rate is set by the four-stage pipeline; the widest step is the 32x30 nanosecond multiply.
// Reset (synchronous, active low) clears only the stage valid bits; data registers hold.
// ----------------------------------------------------------------------------
// calendar_time_to_unix_ns_unit
// Converts a binary calendar date and time into Unix epoch seconds and nanoseconds.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_time_to_unix_ns_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire ct2u_pkg::t_cal_in    i_data,
    output logic                      o_busy,
    output logic                      o_valid,
    output ct2u_pkg::t_epoch_out      o_data
);
    import ct2u_pkg::*;

    // Pipeline:
    //   A: clamp year, month table lookup, leap adjust, time of day in seconds
    //   B: days since 1970 = 365*years + leap days + month days + day-1
    //   C: seconds = days * 86400 + time of day
    //   D: nanoseconds = seconds * 1e9 (output register)
    // No stage ever holds, so every transaction moves one stage per cycle.

    logic     accept;
    logic     day_valid;
    t_day_sum day_sum;

    logic        r_c_valid, n_c_valid;
    logic [31:0] r_c_secs,  n_c_secs;
    logic        r_d_valid, n_d_valid;
    t_epoch_out  r_d_out,   n_d_out;

    logic [32:0] day_secs;

    // Always ready: the pipeline never backs up.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    ct2u_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_cal   (i_data),
        .o_valid (day_valid),
        .o_sum   (day_sum)
    );

    always_comb begin
        // Largest day count stays below 2^32 seconds over the clamped year range.
        day_secs  = 33'(day_sum.days) * 33'(SECS_PER_DAY);
        n_c_secs  = day_secs[31:0] + 32'(day_sum.tod_secs);
        n_c_valid = day_valid;

        n_d_out.epoch_seconds     = r_c_secs;
        n_d_out.epoch_nanoseconds = 62'(r_c_secs * 62'(NS_PER_SEC));
        n_d_valid                 = r_c_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_c_valid <= n_c_valid;
            r_d_valid <= n_d_valid;
        end
        r_c_secs <= n_c_secs;
        r_d_out  <= n_d_out;
    end

    assign o_valid = r_d_valid;
    assign o_data  = r_d_out;

endmodule

`default_nettype wire

FILE: hw/rtl/ct2u_checker.sv
// ----------------------------------------------------------------------------
// ct2u_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_time_to_unix_ns_unit_macros.svh"

module ct2u_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire ct2u_pkg::t_cal_in    i_data,
    input  wire logic                 o_busy,
    input  wire logic                 o_valid,
    input  wire ct2u_pkg::t_epoch_out o_data
);
    import ct2u_pkg::*;

    logic       took;
    logic [3:0] r_rst_hist;  // reset level sampled at each edge, newest in bit 0

    assign took = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        r_rst_hist <= {r_rst_hist[2:0], i_rst_n};
    end

    // Every result strobe traces back to a transaction that passed through stages A, B, C and D.
    `CT2U_ASSERT_IMPL(a_valid_has_source, i_clk, i_rst_n, o_valid, $past(took, 4))

    // A transaction taken while r_rst_hist shows reset off throughout always yields a result.
    `CT2U_ASSERT_IMPL(a_source_has_valid, i_clk, i_rst_n, $past(took, 4) && (&r_rst_hist), o_valid)

    // 1e9 carries 2^9, so nanoseconds end in nine zero bits.
    `CT2U_ASSERT_IMPL(a_ns_low_zero, i_clk, i_rst_n, o_valid, o_data.epoch_nanoseconds[8:0] == 9'd0)

    // A started transaction carries fully driven fields.
    `CT2U_ASSERT_IMPL(a_start_data_known, i_clk, i_rst_n, i_start, !$isunknown(i_data))

    // The converter takes a transaction on every cycle.
    `CT2U_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !o_busy)

endmodule

bind calendar_time_to_unix_ns_unit ct2u_checker u_ct2u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_data  (i_data),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_data  (o_data)
);

`default_nettype wire

FILE: test/calendar_time_to_unix_ns_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_time_to_unix_ns_unit_test
// Self-checking bench for the calendar-to-epoch converter. A clocked driver
// feeds calendar times from a queue of pending dates. A clocked monitor
// compares each strobed result, field by field, with the epoch that a local
// predictor worked out when the date was accepted. The traffic runs directed
// corner dates first. Random dates follow over phases of varying sender idling.
// ----------------------------------------------------------------------------
module calendar_time_to_unix_ns_unit_test;
    import ct2u_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction
    localparam int unsigned DRAIN_CYCLES   = 8;     // pipeline is 4 deep
    localparam int unsigned RESET_CYCLES   = 10;
    localparam int unsigned RANDOM_DATES   = 1330;
    localparam int unsigned PHASE_COUNT    = 4;
    localparam int unsigned MAX_REPORTS    = 10;

    // One queued date plus how the driver should present it.
    typedef struct packed {
        t_cal_in    cal;
        logic [6:0] idle_pct;        // chance per cycle of holding the date back
        logic       hold_for_drain;  // wait until every pending epoch has come back
    } t_pending_date;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    t_cal_in    i_data  = '0;
    logic       o_busy;
    logic       o_valid;
    t_epoch_out o_data;

    t_pending_date pending_dates[$];
    t_epoch_out    expected_epochs[$];

    int unsigned dates_sent     = 0;
    int unsigned epochs_checked = 0;
    int unsigned mismatch_cnt   = 0;
    int unsigned idle_cycles    = 0;

    calendar_time_to_unix_ns_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_data  (i_data),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int unsigned month_len(input int unsigned m, input bit leap);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Walks the years and months one by one. This is slow but plain, and it
    // stands apart from the closed form that the hardware uses.
    function automatic t_epoch_out epoch_of(input t_cal_in cal);
        int unsigned yr;
        int unsigned y;
        int unsigned m;
        int unsigned full_months;
        logic [63:0] days;
        logic [63:0] secs;
        logic [63:0] nanos;
        t_epoch_out  res;
        yr = cal.year_full;
        if (yr < YEAR_FIRST) yr = YEAR_FIRST;
        if (yr > YEAR_LAST)  yr = YEAR_LAST;
        days = '0;
        for (y = YEAR_FIRST; y < yr; y++) begin
            days += is_leap(y) ? 366 : 365;
        end
        // Month 0 counts nothing; anything past December counts a whole year.
        full_months = (cal.month_num == 0) ? 0 : cal.month_num - 1;
        if (full_months > MONTHS_MAX) full_months = MONTHS_MAX;
        for (m = 1; m <= full_months; m++) begin
            days += month_len(m, is_leap(yr));
        end
        // Day 0 behaves as day 1; days past the month end simply add up.
        if (cal.day_of_month != 0) days += cal.day_of_month - 1;
        // Time-of-day fields go in raw, even when out of range.
        secs = days * SECS_PER_DAY + cal.hour_of_day * SECS_PER_HOUR
             + cal.minute_val * SECS_PER_MIN + cal.second_val;
        nanos = secs * NS_PER_SEC;
        res.epoch_seconds     = secs[31:0];
        res.epoch_nanoseconds = nanos[61:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_cal_in make_date(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s);
        t_cal_in cal;
        cal.year_full    = 12'(y);
        cal.month_num    = 4'(mo);
        cal.day_of_month = 5'(d);
        cal.hour_of_day  = 5'(h);
        cal.minute_val   = 6'(mi);
        cal.second_val   = 6'(s);
        return cal;
    endfunction

    // Mostly real dates with the day bounded by the month; the rest raw bits.
    function automatic t_cal_in random_date();
        t_cal_in     cal;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(99) < 85) begin
            cal.year_full    = 12'($urandom_range(YEAR_LAST, YEAR_FIRST));
            cal.month_num    = 4'($urandom_range(12, 1));
            cal.day_of_month = 5'($urandom_range(
                month_len(cal.month_num, is_leap(cal.year_full)), 1));
            cal.hour_of_day  = 5'($urandom_range(23, 0));
            cal.minute_val   = 6'($urandom_range(59, 0));
            cal.second_val   = 6'($urandom_range(59, 0));
        end else begin
            cal = raw[$bits(t_cal_in)-1:0];
        end
        return cal;
    endfunction

    task automatic queue_date(input t_cal_in cal, input int unsigned idle_pct,
                              input bit hold_for_drain);
        t_pending_date pd;
        pd.cal            = cal;
        pd.idle_pct       = 7'(idle_pct);
        pd.hold_for_drain = hold_for_drain;
        pending_dates.push_back(pd);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            if (mismatch_cnt < MAX_REPORTS)
                $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, fname,
                         want, got);
            mismatch_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: a transaction is taken at an edge with start high and busy low.
    // The next date goes out at that same edge, so start stays high across
    // back-to-back transactions with a single assignment per edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_pending_date head;
        logic          taken;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            taken = i_start && !o_busy;
            if (taken) begin
                expected_epochs.push_back(epoch_of(i_data));
                dates_sent++;
            end
            if (!i_start || taken) begin
                if (pending_dates.size() != 0
                    && !(pending_dates[0].hold_for_drain && expected_epochs.size() != 0)
                    && $urandom_range(99) >= pending_dates[0].idle_pct) begin
                    head = pending_dates.pop_front();
                    i_data  <= head.cal;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: o_valid marks a result for exactly one cycle. It is sampled
    // at the edge that ends that cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_epoch_out want;
        if (i_rst_n && o_valid) begin
            if (expected_epochs.size() == 0) begin
                if (mismatch_cnt < MAX_REPORTS)
                    $display("[%0t] result with no date pending: sec %0d ns %0d",
                             $realtime, o_data.epoch_seconds, o_data.epoch_nanoseconds);
                mismatch_cnt++;
            end else begin
                want = expected_epochs.pop_front();
                epochs_checked++;
                check_field("epoch_seconds", want.epoch_seconds, o_data.epoch_seconds);
                check_field("epoch_nanoseconds", want.epoch_nanoseconds,
                            o_data.epoch_nanoseconds);
            end
        end
    end

    // Watchdog: a hung pipeline shows up as a long run of quiet cycles.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed corners, random phases, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        int unsigned idle_pct;

        // Epoch origin, and the last second of the supported range.
        queue_date(make_date(1970, 1, 1, 0, 0, 0), 0, 0);
        queue_date(make_date(2099, 12, 31, 23, 59, 59), 0, 0);
        // Every field at all zeros and at all ones.
        queue_date(make_date(0, 0, 0, 0, 0, 0), 0, 0);
        queue_date(make_date(12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F), 0, 0);
        // Years just outside the range clamp to the nearest end.
        queue_date(make_date(1969, 6, 15, 12, 30, 30), 0, 0);
        queue_date(make_date(2100, 3, 1, 0, 0, 0), 0, 0);
        // Month zero, month thirteen, month fifteen in a leap year.
        queue_date(make_date(2024, 0, 10, 1, 2, 3), 0, 0);
        queue_date(make_date(2023, 13, 1, 0, 0, 0), 0, 0);
        queue_date(make_date(2024, 15, 1, 0, 0, 0), 0, 0);
        // Day zero, and a day past the end of February.
        queue_date(make_date(1999, 5, 0, 8, 0, 0), 0, 0);
        queue_date(make_date(2001, 2, 31, 0, 0, 0), 0, 0);
        // Leap handling: century leap, common year, ordinary leap.
        queue_date(make_date(2000, 2, 29, 23, 59, 59), 0, 0);
        queue_date(make_date(2000, 3, 1, 0, 0, 0), 0, 0);
        queue_date(make_date(1999, 3, 1, 0, 0, 0), 0, 0);
        queue_date(make_date(1972, 3, 1, 0, 0, 0), 0, 0);
        queue_date(make_date(2096, 12, 31, 23, 59, 59), 0, 0);
        // Seconds wrap point of signed 32-bit time.
        queue_date(make_date(2038, 1, 19, 3, 14, 7), 0, 0);
        // Raw out-of-range time-of-day fields.
        queue_date(make_date(1970, 1, 1, 31, 63, 63), 0, 0);
        queue_date(make_date(2050, 7, 4, 24, 60, 60), 0, 0);

        // Phases: no gaps, heavy gaps, no gaps, moderate gaps. The first date
        // of each phase waits for the pipeline to empty.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            idle_pct = (phase == 1) ? 56 : (phase == 3) ? 28 : 0;
            for (n = 0; n < RANDOM_DATES / PHASE_COUNT; n++)
                queue_date(random_date(), idle_pct, n == 0);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_dates.size() != 0 || i_start || expected_epochs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d calendar times (corner dates, then %0d idle phases);",
                 dates_sent, PHASE_COUNT);
        $display("%0d epochs compared, %0d field mismatches.", epochs_checked,
                 mismatch_cnt);
        if (mismatch_cnt == 0 && expected_epochs.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: calendar_time_to_unix_ns_unit.f
+incdir+hw/rtl
hw/rtl/ct2u_pkg.sv
hw/rtl/ct2u_day_count.sv
hw/rtl/calendar_time_to_unix_ns_unit.sv
hw/rtl/ct2u_checker.sv
test/calendar_time_to_unix_ns_unit_test.sv
